// ===== hw/rtl/kkm_pkg.sv =====
// shared types and constants of the keyed k-mer code mapper
package kkm_pkg;

    localparam int unsigned MAX_ALPHABET = 8;
    localparam int unsigned MAX_ORDER    = 8;
    localparam int unsigned CODE_W       = 16;
    localparam int unsigned ACC_W        = 24;
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned DIGIT_W      = 3;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CHAR    = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;

    localparam logic [1:0] REG_ALPHABET = 2'd0;
    localparam logic [1:0] REG_SIZE     = 2'd1;
    localparam logic [1:0] REG_ORDER    = 2'd2;

    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ERR,
        OP_ENC,
        OP_DEC
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] addr;
        logic [CODE_W-1:0] data;
        logic [1:0]        err;
    } q_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRD,
        ST_IRD,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/keyed_kmer_code_mapper.sv =====
// top level of the keyed k-mer code mapper: settings registers and unit wiring
// Loads and encode characters are taken one beat per cycle while the two-entry
// work queue has room. A completed encode group passes through the back end as a
// forward table read, then a result. A decode for group order k holds the back
// end for one inverse table read, the shared radix divider for each of the k
// digits, then one emitted character per digit.
// The tables need no clearing pass; an entry must be loaded before it is read.
module keyed_kmer_code_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,  // command
    input  logic [55:0] s_tdata,  // char_in, table_index, table_value, code_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,  // kind
    output logic        m_tlast,
    output logic [31:0] m_tdata   // code_out, char_out, error
);
    import kkm_pkg::*;

    logic [63:0] alpha_reg;
    logic [3:0]  size_reg;
    logic [3:0]  order_reg;
    logic [3:0]  radix;
    logic [3:0]  order;
    logic        cfg_clear;
    logic        q_push, q_pop, q_full, q_empty;
    q_entry_t    q_wdata, q_rdata;

    assign radix = (size_reg == '0) ? 4'd1 :
                   (size_reg > 4'(MAX_ALPHABET)) ? 4'(MAX_ALPHABET) : size_reg;
    assign order = (order_reg == '0) ? 4'd1 :
                   (order_reg > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_reg;
    assign cfg_clear = cfg_wr_en && (cfg_index == REG_ALPHABET ||
                       cfg_index == REG_SIZE || cfg_index == REG_ORDER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '0;
            size_reg  <= 4'd4;
            order_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHABET: alpha_reg <= cfg_data;
                REG_SIZE:     size_reg  <= cfg_data[3:0];
                REG_ORDER:    order_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    kkm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_clear(cfg_clear),
        .radix    (radix),
        .order    (order),
        .alphabet (alpha_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    kkm_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .full   (q_full),
        .empty  (q_empty)
    );

    kkm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .radix   (radix),
        .order   (order),
        .alphabet(alpha_reg),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tdata (m_tdata)
    );

endmodule

// ===== hw/rtl/kkm_front.sv =====
// front end: accepts beats, runs the encode accumulator, issues work items
module kkm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_clear,
    input  logic [3:0]        radix,
    input  logic [3:0]        order,
    input  logic [63:0]       alphabet,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,
    input  logic [55:0]       s_tdata,
    input  logic              q_full,
    output logic              q_push,
    output kkm_pkg::q_entry_t q_wdata
);
    import kkm_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             accept;
    logic [7:0]       ch;
    logic             found;
    logic [2:0]       digit;
    logic [27:0]      prod;
    logic [ACC_W-1:0] acc_new;
    logic [3:0]       cnt_new;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign ch       = s_tdata[7:0];

    always_comb begin
        found = 1'b0;
        digit = '0;
        for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
            if (4'(i) < radix && alphabet[8*i +: 8] == ch) begin
                found = 1'b1;
                digit = 3'(i);
            end
        end
        prod    = acc_reg * radix;
        acc_new = prod[ACC_W-1:0] + {21'b0, digit};
        cnt_new = cnt_reg + 4'd1;
    end

    always_comb begin
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        q_push       = 1'b0;
        q_wdata.op   = OP_LOAD;
        q_wdata.addr = s_tdata[23:8];
        q_wdata.data = s_tdata[39:24];
        q_wdata.err  = ERR_NONE;
        if (accept) begin
            case (s_tuser)
                CMD_LOAD: begin
                    q_push = 1'b1;
                end
                CMD_ENCODE: begin
                    if (!found) begin
                        q_push      = 1'b1;
                        q_wdata.op  = OP_ERR;
                        q_wdata.err = ERR_CHAR;
                        acc_next    = '0;
                        cnt_next    = '0;
                    end else if (cnt_new >= order) begin
                        q_push   = 1'b1;
                        acc_next = '0;
                        cnt_next = '0;
                        if (acc_new[ACC_W-1:CODE_W] != '0) begin
                            q_wdata.op  = OP_ERR;
                            q_wdata.err = ERR_RANGE;
                        end else begin
                            q_wdata.op   = OP_ENC;
                            q_wdata.addr = acc_new[CODE_W-1:0];
                        end
                    end else begin
                        acc_next = acc_new;
                        cnt_next = cnt_new;
                    end
                end
                CMD_DECODE: begin
                    q_push       = 1'b1;
                    q_wdata.op   = OP_DEC;
                    q_wdata.addr = s_tdata[55:40];
                end
                default: begin
                end
            endcase
        end
        if (cfg_clear) begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/kkm_queue.sv =====
// two-entry work queue between front and back end
module kkm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  kkm_pkg::q_entry_t wdata,
    input  logic              pop,
    output kkm_pkg::q_entry_t rdata,
    output logic              full,
    output logic              empty
);
    import kkm_pkg::*;

    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/kkm_back.sv =====
// back end: permutation tables, digit splitter and result register
module kkm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [3:0]        radix,
    input  logic [3:0]        order,
    input  logic [63:0]       alphabet,
    input  logic              q_empty,
    input  kkm_pkg::q_entry_t q_rdata,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tuser,
    output logic              m_tlast,
    output logic [31:0]       m_tdata
);
    import kkm_pkg::*;

    logic [CODE_W-1:0] fwd_mem [1 << CODE_W];
    logic [CODE_W-1:0] inv_mem [1 << CODE_W];
    logic [CODE_W-1:0] fwd_rd_reg, inv_rd_reg;
    logic              mem_we;

    back_state_t state_reg, state_next;
    logic [CODE_W-1:0]  num_reg, num_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [1:0]         step_reg, step_next;
    logic [DIGIT_W-1:0] dcnt_reg, dcnt_next;
    logic [DIGIT_W-1:0] digits_reg [MAX_ORDER];
    logic               dig_we;

    logic              valid_reg, valid_next;
    logic              kind_reg, kind_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [1:0]        err_reg, err_next;
    logic              last_reg, last_next;

    logic               can_emit;
    logic [3:0]         r;
    logic [CODE_W-1:0]  n;
    logic [DIGIT_W-1:0] kmax;
    logic [DIGIT_W-1:0] dsel;

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'b0, err_reg, char_reg, code_reg};
    assign can_emit = !valid_reg || m_tready;
    assign kmax     = 3'(order - 4'd1);
    assign dsel     = digits_reg[dcnt_reg];

    // read data is held while the result waits for the output register
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fwd_mem[q_rdata.addr] <= q_rdata.data;
        end
        if (q_pop) begin
            fwd_rd_reg <= fwd_mem[q_rdata.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            inv_mem[q_rdata.data] <= q_rdata.addr;
        end
        inv_rd_reg <= inv_mem[q_rdata.addr];
    end

    // four restoring steps of num / radix per cycle
    always_comb begin
        r = {1'b0, rem_reg};
        n = num_reg;
        for (int i = 0; i < 4; i++) begin
            r = {r[2:0], n[CODE_W-1]};
            n = {n[CODE_W-2:0], 1'b0};
            if (r >= radix) begin
                r    = r - radix;
                n[0] = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        dcnt_next  = dcnt_reg;
        dig_we     = 1'b0;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        code_next  = code_reg;
        char_next  = char_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    case (q_rdata.op)
                        OP_LOAD: begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_ERR: begin
                            if (can_emit) begin
                                q_pop      = 1'b1;
                                valid_next = 1'b1;
                                kind_next  = KIND_CODE;
                                code_next  = '0;
                                char_next  = '0;
                                err_next   = q_rdata.err;
                                last_next  = 1'b1;
                            end
                        end
                        OP_ENC: begin
                            q_pop      = 1'b1;
                            state_next = ST_FRD;
                        end
                        OP_DEC: begin
                            q_pop      = 1'b1;
                            state_next = ST_IRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FRD: begin
                if (can_emit) begin
                    valid_next = 1'b1;
                    kind_next  = KIND_CODE;
                    code_next  = fwd_rd_reg;
                    char_next  = '0;
                    err_next   = ERR_NONE;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IRD: begin
                num_next   = inv_rd_reg;
                rem_next   = '0;
                step_next  = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                num_next  = n;
                rem_next  = r[2:0];
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    dig_we   = 1'b1;
                    rem_next = '0;
                    if (dcnt_reg == kmax) begin
                        state_next = ST_EMIT;
                    end else begin
                        dcnt_next = dcnt_reg + 3'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    valid_next = 1'b1;
                    kind_next  = KIND_CHAR;
                    code_next  = '0;
                    char_next  = alphabet[8*dsel +: 8];
                    err_next   = ERR_NONE;
                    last_next  = dcnt_reg == '0;
                    if (dcnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        dcnt_next = dcnt_reg - 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dig_we) begin
            digits_reg[dcnt_reg] <= r[2:0];
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        kind_reg <= kind_next;
        code_reg <= code_next;
        char_reg <= char_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            dcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dcnt_reg  <= dcnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== tb/tb_keyed_kmer_code_mapper.sv =====
// testbench for the keyed k-mer code mapper: random and directed beats checked by a scoreboard
`timescale 1ns / 100ps

module tb_keyed_kmer_code_mapper;
    import kkm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned N_RAND = 70;
    localparam int unsigned SETTLE = 64;
    localparam int unsigned LIMIT  = 300000;

    typedef struct {
        logic       kind;
        logic [15:0] code;
        logic [7:0] ch;
        logic [1:0] err;
        logic       last;
    } mapped_t;

    class mapper_scoreboard;
        logic [15:0] fwd [int];
        logic [15:0] inv [int];
        logic [15:0] inv_keys [$];
        logic [23:0] acc;
        logic [3:0]  nchars;
        logic [63:0] alpha;
        logic [3:0]  size_reg;
        logic [3:0]  order_reg;
        mapped_t     pending [$];
        int          errors;
        int          n_checked;
        int          n_in;

        function void clear();
            acc = '0; nchars = '0; alpha = '0; size_reg = 4'd4; order_reg = 4'd1;
            errors = 0; n_checked = 0; n_in = 0;
        endfunction

        function int unsigned radix();
            if (size_reg < 1) return 1;
            if (size_reg > MAX_ALPHABET) return MAX_ALPHABET;
            return size_reg;
        endfunction

        function int unsigned group_len();
            if (order_reg < 1) return 1;
            if (order_reg > MAX_ORDER) return MAX_ORDER;
            return order_reg;
        endfunction

        function int digit_of(logic [7:0] c);
            for (int i = 0; i < radix(); i++)
                if (alpha[8*i +: 8] == c) return i;
            return -1;
        endfunction

        // natural code the group would complete with, or -1
        function int closing_code(logic [7:0] c);
            int d;
            d = digit_of(c);
            if (d < 0 || nchars + 1 < group_len()) return -1;
            return ((acc * radix() + d) & 24'hFFFFFF);
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_ALPHABET: alpha = val;
                REG_SIZE: size_reg = val[3:0];
                REG_ORDER: order_reg = val[3:0];
                default: return;
            endcase
            acc = '0;
            nchars = '0;
        endfunction

        function void push(logic kind, logic [15:0] code, logic [7:0] ch,
                           logic [1:0] err, logic last);
            mapped_t r;
            r.kind = kind; r.code = code; r.ch = ch; r.err = err; r.last = last;
            pending.push_back(r);
        endfunction

        function void note_input(logic [1:0] cmd, logic [55:0] d);
            int dg, k, b, nat, p, di;
            b = radix();
            k = group_len();
            n_in++;
            case (cmd)
                CMD_LOAD: begin
                    fwd[d[23:8]] = d[39:24];
                    inv[d[39:24]] = d[23:8];
                    inv_keys.push_back(d[39:24]);
                end
                CMD_ENCODE: begin
                    dg = digit_of(d[7:0]);
                    if (dg < 0) begin
                        acc = '0; nchars = '0;
                        push(KIND_CODE, 16'd0, 8'd0, ERR_CHAR, 1'b1);
                    end else begin
                        acc = 24'((acc * b + dg) & 24'hFFFFFF);
                        nchars = nchars + 4'd1;
                        if (nchars >= k) begin
                            nat = acc;
                            acc = '0; nchars = '0;
                            if (nat >= 65536)
                                push(KIND_CODE, 16'd0, 8'd0, ERR_RANGE, 1'b1);
                            else
                                push(KIND_CODE, fwd[nat], 8'd0, ERR_NONE, 1'b1);
                        end
                    end
                end
                CMD_DECODE: begin
                    nat = inv[d[55:40]];
                    for (int i = 0; i < k; i++) begin
                        p = 1;
                        for (int j = 0; j + 1 + i < k; j++) p *= b;
                        di = (nat / p) % b;
                        push(KIND_CHAR, 16'd0, alpha[8*di +: 8], ERR_NONE, i + 1 == k);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        endtask

        task check_result(logic kind, logic last, logic [31:0] d);
            mapped_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", d, 0);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (kind !== e.kind) report("kind", kind, e.kind);
            if (last !== e.last) report("last", last, e.last);
            if (d[15:0] !== e.code) report("code_out", d[15:0], e.code);
            if (d[23:16] !== e.ch) report("char_out", d[23:16], e.ch);
            if (d[25:24] !== e.err) report("error", d[25:24], e.err);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;   // command
    logic [55:0] s_tdata = '0;   // char_in, table_index, table_value, code_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;        // kind
    logic        m_tlast;
    logic [31:0] m_tdata;        // code_out, char_out, error

    mapper_scoreboard sb = new();
    int  idle_mode = 2;
    int  cycles = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  n_rand = 0;

    keyed_kmer_code_mapper uut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tlast, m_tdata);
        if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_mode == 0) begin
            m_tready <= ($urandom % 100) >= 80;
        end else if (idle_mode == 1) begin
            m_tready <= ($urandom % 100) >= 35;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task send_beat(logic [1:0] cmd, logic [55:0] d);
        int p;
        s_tuser <= cmd;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, d);
        p = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 80 : 0;
        if (($urandom % 100) < p) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    function logic [55:0] pack(logic [7:0] c, logic [15:0] idx, logic [15:0] val,
                               logic [15:0] code);
        return {code, val, idx, c};
    endfunction

    task load_entry(logic [15:0] idx, logic [15:0] val);
        send_beat(CMD_LOAD, pack(8'($urandom), idx, val, 16'($urandom)));
    endtask

    // loads the forward entry first when the group would close on an unwritten one
    task encode_char(logic [7:0] c);
        int nat;
        nat = sb.closing_code(c);
        if (nat >= 0 && nat < 65536 && !sb.fwd.exists(nat))
            load_entry(16'(nat), 16'($urandom));
        send_beat(CMD_ENCODE, pack(c, 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task decode_code(logic [15:0] code);
        send_beat(CMD_DECODE, pack(8'($urandom), 16'($urandom), 16'($urandom), code));
    endtask

    task decode_known();
        if (sb.inv_keys.size() == 0) load_entry(16'($urandom), 16'($urandom));
        decode_code(sb.inv_keys[$urandom_range(0, sb.inv_keys.size() - 1)]);
    endtask

    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task setup(logic [63:0] a, logic [3:0] sz, logic [3:0] ord);
        logic [63:0] vals [3];
        vals[0] = a; vals[1] = 64'(sz); vals[2] = 64'(ord);
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= (i == 0) ? vals[i] : {$urandom, $urandom} & ~64'hF | vals[i];
            @(posedge aclk);
            sb.write_reg(2'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task random_beats(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            idle_mode = (n_rand < N_RAND / 3) ? 0 : (n_rand < 2 * N_RAND / 3) ? 1 : 2;
            n_rand++;
            r = $urandom % 100;
            if (r < 15)
                load_entry(16'($urandom), 16'($urandom));
            else if (r < 65)
                encode_char(($urandom % 10 == 0) ? 8'($urandom)
                            : sb.alpha[8 * $urandom_range(0, sb.radix() - 1) +: 8]);
            else if (r < 95)
                decode_known();
            else
                send_beat(CMD_UNUSED, 56'({$urandom, $urandom}));
        end
    endtask

    initial begin
        sb.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ACGT, groups of three
        setup(64'h0000_0000_5447_4341, 4'd4, 4'd3);
        load_entry(16'hFFFF, 16'hFFFF);
        load_entry(16'h0000, 16'h0000);
        load_entry(16'h0006, 16'hA5C3);
        encode_char("A");
        encode_char("C");
        encode_char("G");
        encode_char("T");
        load_entry(16'h1234, 16'h5A5A);
        decode_code(16'hA5C3);
        encode_char("T");
        encode_char("T");
        encode_char("A");
        encode_char("Z");
        encode_char("A");
        decode_code(16'hFFFF);
        decode_code(16'h0000);
        send_beat(CMD_UNUSED, '1);
        encode_char(8'h00);
        encode_char(8'hFF);
        settle();

        // all-ones alphabet, radix one: the code is always zero
        setup('1, 4'd1, 4'd1);
        encode_char(8'hFF);
        encode_char(8'h00);
        decode_code(16'hFFFF);
        settle();

        idle_mode = 0;
        setup({$urandom, $urandom}, 4'd8, 4'd8);
        hold_req = 1;
        for (int i = 0; i < 12; i++) decode_known();
        random_beats(10);
        settle();
        setup(64'h0, 4'd0, 4'd0);
        random_beats(10);
        settle();
        setup({16'h4141, 16'h4242, $urandom}, 4'd15, 4'd15);
        random_beats(10);
        settle();
        setup({$urandom, $urandom}, 4'd2, 4'd5);
        random_beats(10);
        settle();
        setup({$urandom, $urandom}, 4'd3, 4'd4);
        random_beats(10);
        settle();
        setup('1, 4'd1, 4'd1);
        random_beats(10);
        settle();
        setup({$urandom, $urandom}, 4'd5, 4'd6);
        random_beats(10);
        settle();

        $display("%0d input beats sent, %0d result beats checked", sb.n_in, sb.n_checked);
        $display("covered loads, encode groups, decodes, bad chars and register extremes");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
